// File: hdl/cpc_pkg.sv
package cpc_pkg;

   localparam int MAT_FRAC     = 14;
   localparam int MAT_WIDTH    = 20;
   localparam int QPROD_WIDTH  = 18;
   localparam int HEIGHT_RESET = 131072;
   localparam int RADIUS_RESET = 32768;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NO_TRANSFORM = 2'd1,
      STATUS_BAD_AXIS     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      AXIS_X       = 2'd0,
      AXIS_Y       = 2'd1,
      AXIS_Z       = 2'd2,
      AXIS_INVALID = 2'd3
   } axis_type;

   typedef enum logic [2:0] {
      CSR_CENTER_X       = 3'd0,
      CSR_CENTER_Y       = 3'd1,
      CSR_CENTER_Z       = 3'd2,
      CSR_CAPSULE_HEIGHT = 3'd3,
      CSR_CAPSULE_RADIUS = 3'd4,
      CSR_AXIS_SELECT    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic       valid;
      status_type status;
   } ctl_type;

endpackage

// File: hdl/cpc_req_if.sv
interface cpc_req_if #(parameter int COORD_WIDTH = 32, parameter int QUAT_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic signed [COORD_WIDTH-1:0] point_z;
   logic signed [COORD_WIDTH-1:0] pos_x;
   logic signed [COORD_WIDTH-1:0] pos_y;
   logic signed [COORD_WIDTH-1:0] pos_z;
   logic signed [QUAT_WIDTH-1:0]  rot_w;
   logic signed [QUAT_WIDTH-1:0]  rot_x;
   logic signed [QUAT_WIDTH-1:0]  rot_y;
   logic signed [QUAT_WIDTH-1:0]  rot_z;
   logic                          transform_present;

   modport source (output valid, point_x, point_y, point_z, pos_x, pos_y, pos_z,
                   rot_w, rot_x, rot_y, rot_z, transform_present, input ready);
   modport sink (input valid, point_x, point_y, point_z, pos_x, pos_y, pos_z,
                 rot_w, rot_x, rot_y, rot_z, transform_present, output ready);
endinterface

// File: hdl/cpc_rsp_if.sv
interface cpc_rsp_if;
   logic       valid;
   logic       ready;
   logic       inside_res;
   logic [1:0] status;

   modport source (output valid, inside_res, status, input ready);
   modport sink (input valid, inside_res, status, output ready);
endinterface

// File: hdl/cpc_rotate.sv
module cpc_rotate #(
   parameter int COORD_WIDTH = 32,
   parameter int QUAT_WIDTH  = 16,
   localparam int DIST_WIDTH = COORD_WIDTH + cpc_pkg::MAT_WIDTH - 10,
   localparam int MW         = cpc_pkg::MAT_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  cpc_pkg::ctl_type              ctl_in,
   input  logic signed [COORD_WIDTH-1:0] point [3],
   input  logic signed [COORD_WIDTH-1:0] pos [3],
   input  logic signed [QUAT_WIDTH-1:0]  rot_w,
   input  logic signed [QUAT_WIDTH-1:0]  rot_x,
   input  logic signed [QUAT_WIDTH-1:0]  rot_y,
   input  logic signed [QUAT_WIDTH-1:0]  rot_z,
   input  logic signed [COORD_WIDTH-1:0] center [3],
   input  logic [1:0]                    axis_select,
   output cpc_pkg::ctl_type              ctl_out,
   output logic signed [DIST_WIDTH-1:0]  delta [3],
   output logic signed [MW-1:0]          axis [3]
);

   localparam int QF  = QUAT_WIDTH - 2;
   localparam int PS  = 2 * QF - cpc_pkg::MAT_FRAC;
   localparam int QPW = cpc_pkg::QPROD_WIDTH;
   localparam int PPW = COORD_WIDTH + 1;
   localparam int MCW = MW + COORD_WIDTH;
   localparam int ACW = MCW + 2;
   localparam logic signed [MW-1:0] ONE = MW'(1 << cpc_pkg::MAT_FRAC);

   function automatic logic signed [QPW-1:0] qprod(input logic signed [QUAT_WIDTH-1:0] a,
                                                   input logic signed [QUAT_WIDTH-1:0] b);
      logic signed [2*QUAT_WIDTH-1:0] p;
      p = a * b;
      return QPW'(p >>> PS);
   endfunction

   cpc_pkg::ctl_type ctl_ff [4];

   // stage 1: quaternion products
   logic signed [QPW-1:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic signed [PPW-1:0] pp1_ff [3];
   // stage 2: matrix
   logic signed [MW-1:0]  m_ff [3][3];
   logic signed [MW-1:0]  m_in [3][3];
   logic signed [PPW-1:0] pp2_ff [3];
   // stage 3: products with center, axis column
   logic signed [MCW-1:0] mc_ff [3][3];
   logic signed [MW-1:0]  a3_ff [3];
   logic signed [MW-1:0]  a3_in [3];
   logic signed [PPW-1:0] pp3_ff [3];
   // stage 4: offset from world center
   logic signed [DIST_WIDTH-1:0] d_ff [3];
   logic signed [DIST_WIDTH-1:0] d_in [3];
   logic signed [MW-1:0]         a4_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) ctl_ff[i] <= '0;
      end else if (enable) begin
         ctl_ff[0] <= ctl_in;
         for (int i = 1; i < 4; i++) ctl_ff[i] <= ctl_ff[i-1];
      end
   end

   always_comb begin
      m_in[0][0] = ONE - ((MW'(yy_ff) + MW'(zz_ff)) <<< 1);
      m_in[0][1] = (MW'(xy_ff) - MW'(wz_ff)) <<< 1;
      m_in[0][2] = (MW'(xz_ff) + MW'(wy_ff)) <<< 1;
      m_in[1][0] = (MW'(xy_ff) + MW'(wz_ff)) <<< 1;
      m_in[1][1] = ONE - ((MW'(xx_ff) + MW'(zz_ff)) <<< 1);
      m_in[1][2] = (MW'(yz_ff) - MW'(wx_ff)) <<< 1;
      m_in[2][0] = (MW'(xz_ff) - MW'(wy_ff)) <<< 1;
      m_in[2][1] = (MW'(yz_ff) + MW'(wx_ff)) <<< 1;
      m_in[2][2] = ONE - ((MW'(xx_ff) + MW'(yy_ff)) <<< 1);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         case (cpc_pkg::axis_type'(axis_select))
            cpc_pkg::AXIS_Y: a3_in[i] = m_ff[i][1];
            cpc_pkg::AXIS_Z: a3_in[i] = m_ff[i][2];
            default:         a3_in[i] = m_ff[i][0];
         endcase
      end
   end

   always_comb begin
      logic signed [ACW-1:0] acc;
      for (int i = 0; i < 3; i++) begin
         acc = ACW'(mc_ff[i][0]) + ACW'(mc_ff[i][1]) + ACW'(mc_ff[i][2]);
         d_in[i] = DIST_WIDTH'(pp3_ff[i]) - DIST_WIDTH'(acc >>> cpc_pkg::MAT_FRAC);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         xx_ff <= qprod(rot_x, rot_x);
         yy_ff <= qprod(rot_y, rot_y);
         zz_ff <= qprod(rot_z, rot_z);
         xy_ff <= qprod(rot_x, rot_y);
         xz_ff <= qprod(rot_x, rot_z);
         yz_ff <= qprod(rot_y, rot_z);
         wx_ff <= qprod(rot_w, rot_x);
         wy_ff <= qprod(rot_w, rot_y);
         wz_ff <= qprod(rot_w, rot_z);
         for (int i = 0; i < 3; i++) begin
            pp1_ff[i] <= PPW'(point[i]) - PPW'(pos[i]);
            pp2_ff[i] <= pp1_ff[i];
            pp3_ff[i] <= pp2_ff[i];
            a3_ff[i]  <= a3_in[i];
            d_ff[i]   <= d_in[i];
            a4_ff[i]  <= a3_ff[i];
            for (int j = 0; j < 3; j++) begin
               m_ff[i][j]  <= m_in[i][j];
               mc_ff[i][j] <= m_ff[i][j] * center[j];
            end
         end
      end
   end

   assign ctl_out = ctl_ff[3];
   assign delta   = d_ff;
   assign axis    = a4_ff;

endmodule

// File: hdl/cpc_project.sv
module cpc_project #(
   parameter int COORD_WIDTH = 32,
   localparam int DIST_WIDTH = COORD_WIDTH + cpc_pkg::MAT_WIDTH - 10,
   localparam int MW         = cpc_pkg::MAT_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  cpc_pkg::ctl_type             ctl_in,
   input  logic signed [DIST_WIDTH-1:0] delta [3],
   input  logic signed [MW-1:0]         axis [3],
   input  logic [COORD_WIDTH-2:0]       capsule_height,
   input  logic [COORD_WIDTH-2:0]       capsule_radius,
   output cpc_pkg::ctl_type             ctl_out,
   output logic                         inside_res
);

   localparam int DW  = DIST_WIDTH;
   localparam int L   = DW / 2;
   localparam int PHW = DW - L + MW;
   localparam int PLW = L + 1 + MW;
   localparam int SW  = DW + MW + 2;
   localparam int SSW = SW - cpc_pkg::MAT_FRAC;
   localparam int TAW = COORD_WIDTH + MW;
   localparam int EW  = DW + 1;
   localparam int LE  = EW / 2;
   localparam int HHW = 2 * (EW - LE);
   localparam int HLW = EW + 1;
   localparam int LLW = 2 * LE;
   localparam int SQW = 2 * EW + 2;
   localparam int RDW = COORD_WIDTH - 1;
   localparam int LR  = RDW / 2;
   localparam int RW  = 2 * RDW;
   localparam int NS  = 8;

   cpc_pkg::ctl_type ctl_ff [NS];

   logic signed [PHW-1:0] ph_ff [3];
   logic signed [PLW-1:0] pl_ff [3];
   logic signed [SSW-1:0] s_ff;
   logic signed [SSW-1:0] s_in;
   logic signed [COORD_WIDTH-1:0] tau_ff;
   logic signed [COORD_WIDTH-1:0] tau_in;
   logic signed [TAW-1:0] ta_ff [3];
   logic signed [EW-1:0]  e_ff [3];
   logic signed [HHW-1:0] hh_ff [3];
   logic signed [HLW-1:0] hl_ff [3];
   logic [LLW-1:0]        ll_ff [3];
   logic [2*(RDW-LR)-1:0] rhh_ff;
   logic [RDW:0]          rhl_ff;
   logic [2*LR-1:0]       rll_ff;
   logic signed [SQW-1:0] sq_ff [3];
   logic [RW-1:0]         r2_ff;
   logic                  inside_ff;

   logic signed [DW-1:0] d5_ff [3], d6_ff [3], d7_ff [3], d8_ff [3];
   logic signed [MW-1:0] a5_ff [3], a6_ff [3], a7_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) ctl_ff[i] <= '0;
      end else if (enable) begin
         ctl_ff[0] <= ctl_in;
         for (int i = 1; i < NS; i++) ctl_ff[i] <= ctl_ff[i-1];
      end
   end

   always_comb begin
      logic signed [SW-1:0] dot;
      dot = '0;
      for (int i = 0; i < 3; i++) dot = dot + (SW'(ph_ff[i]) <<< L) + SW'(pl_ff[i]);
      s_in = SSW'(dot >>> cpc_pkg::MAT_FRAC);
   end

   always_comb begin
      logic signed [COORD_WIDTH-1:0] hdiff;
      logic signed [COORD_WIDTH-1:0] h;
      hdiff = $signed({2'b00, capsule_height[COORD_WIDTH-2:1]})
            - $signed({1'b0, capsule_radius});
      h = hdiff[COORD_WIDTH-1] ? '0 : hdiff;
      if (s_ff > SSW'(h)) tau_in = h;
      else if (s_ff < -SSW'(h)) tau_in = -h;
      else tau_in = COORD_WIDTH'(s_ff);
   end

   always_ff @(posedge clock) begin
      logic signed [SQW-1:0] tot;
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            ph_ff[i] <= $signed(delta[i][DW-1:L]) * axis[i];
            pl_ff[i] <= $signed({1'b0, delta[i][L-1:0]}) * axis[i];
            d5_ff[i] <= delta[i];
            a5_ff[i] <= axis[i];
            d6_ff[i] <= d5_ff[i];
            a6_ff[i] <= a5_ff[i];
            d7_ff[i] <= d6_ff[i];
            a7_ff[i] <= a6_ff[i];
            ta_ff[i] <= tau_ff * a7_ff[i];
            d8_ff[i] <= d7_ff[i];
            e_ff[i]  <= EW'(d8_ff[i]) - EW'(ta_ff[i] >>> cpc_pkg::MAT_FRAC);
            hh_ff[i] <= $signed(e_ff[i][EW-1:LE]) * $signed(e_ff[i][EW-1:LE]);
            hl_ff[i] <= $signed(e_ff[i][EW-1:LE]) * $signed({1'b0, e_ff[i][LE-1:0]});
            ll_ff[i] <= e_ff[i][LE-1:0] * e_ff[i][LE-1:0];
            sq_ff[i] <= (SQW'(hh_ff[i]) <<< (2 * LE)) + (SQW'(hl_ff[i]) <<< (LE + 1))
                      + $signed(SQW'(ll_ff[i]));
         end
         s_ff   <= s_in;
         tau_ff <= tau_in;
         rhh_ff <= capsule_radius[RDW-1:LR] * capsule_radius[RDW-1:LR];
         rhl_ff <= capsule_radius[RDW-1:LR] * capsule_radius[LR-1:0];
         rll_ff <= capsule_radius[LR-1:0] * capsule_radius[LR-1:0];
         r2_ff  <= (RW'(rhh_ff) << (2 * LR)) + (RW'(rhl_ff) << (LR + 1)) + RW'(rll_ff);
         tot = sq_ff[0] + sq_ff[1] + sq_ff[2];
         inside_ff <= (tot <= $signed(SQW'(r2_ff)))
                   && (ctl_ff[NS-2].status == cpc_pkg::STATUS_OK);
      end
   end

   assign ctl_out    = ctl_ff[NS-1];
   assign inside_res = inside_ff;

endmodule

// File: hdl/capsule_point_containment.sv
// Point-in-capsule test. Each transaction carries a query point and the
// object's world transform; the result says whether the point lies inside
// or on the capsule held in the csr_ registers, with a status code (no
// transform, or axis code 3, gives outside). Throughput is one transaction
// per clock while rsp is not stalled; rsp valid rises when a transaction
// leaves the 12-stage arithmetic pipeline (rotation matrix, world center,
// projection, clamp, squared distance, compare), whose first stage loads
// at acceptance. A stall on rsp freezes the whole pipeline, and req ready
// drops only while a result waits untaken. Write the csr_ registers only
// while no transaction is in flight.
module capsule_point_containment #(
   parameter int COORD_WIDTH = 32,
   parameter int QUAT_WIDTH  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   cpc_req_if.sink                req_chan,
   cpc_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [COORD_WIDTH-1:0] csr_wdata
);

   localparam int DW = COORD_WIDTH + cpc_pkg::MAT_WIDTH - 10;
   localparam int MW = cpc_pkg::MAT_WIDTH;

   logic signed [COORD_WIDTH-1:0] center_ff [3];
   logic [COORD_WIDTH-2:0]        height_ff;
   logic [COORD_WIDTH-2:0]        radius_ff;
   logic [1:0]                    axis_ff;

   logic                          enable;
   cpc_pkg::ctl_type              ctl_in, ctl_mid, ctl_out;
   logic signed [COORD_WIDTH-1:0] point [3];
   logic signed [COORD_WIDTH-1:0] pos [3];
   logic signed [DW-1:0]          delta [3];
   logic signed [MW-1:0]          axis [3];
   logic                          hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) center_ff[i] <= '0;
         height_ff <= (COORD_WIDTH-1)'(cpc_pkg::HEIGHT_RESET);
         radius_ff <= (COORD_WIDTH-1)'(cpc_pkg::RADIUS_RESET);
         axis_ff   <= cpc_pkg::AXIS_Y;
      end else if (csr_we) begin
         unique case (cpc_pkg::csr_index_type'(csr_index))
            cpc_pkg::CSR_CENTER_X:       center_ff[0] <= csr_wdata;
            cpc_pkg::CSR_CENTER_Y:       center_ff[1] <= csr_wdata;
            cpc_pkg::CSR_CENTER_Z:       center_ff[2] <= csr_wdata;
            cpc_pkg::CSR_CAPSULE_HEIGHT: height_ff <= csr_wdata[COORD_WIDTH-2:0];
            cpc_pkg::CSR_CAPSULE_RADIUS: radius_ff <= csr_wdata[COORD_WIDTH-2:0];
            cpc_pkg::CSR_AXIS_SELECT:    axis_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   assign enable         = !ctl_out.valid || rsp_chan.ready;
   assign req_chan.ready = enable;

   always_comb begin
      ctl_in.valid = req_chan.valid;
      if (!req_chan.transform_present) ctl_in.status = cpc_pkg::STATUS_NO_TRANSFORM;
      else if (axis_ff == cpc_pkg::AXIS_INVALID) ctl_in.status = cpc_pkg::STATUS_BAD_AXIS;
      else ctl_in.status = cpc_pkg::STATUS_OK;
   end

   assign point[0] = req_chan.point_x;
   assign point[1] = req_chan.point_y;
   assign point[2] = req_chan.point_z;
   assign pos[0]   = req_chan.pos_x;
   assign pos[1]   = req_chan.pos_y;
   assign pos[2]   = req_chan.pos_z;

   cpc_rotate #(.COORD_WIDTH(COORD_WIDTH), .QUAT_WIDTH(QUAT_WIDTH)) u_rotate (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .ctl_in      (ctl_in),
      .point       (point),
      .pos         (pos),
      .rot_w       (req_chan.rot_w),
      .rot_x       (req_chan.rot_x),
      .rot_y       (req_chan.rot_y),
      .rot_z       (req_chan.rot_z),
      .center      (center_ff),
      .axis_select (axis_ff),
      .ctl_out     (ctl_mid),
      .delta       (delta),
      .axis        (axis)
   );

   cpc_project #(.COORD_WIDTH(COORD_WIDTH)) u_project (
      .clock          (clock),
      .reset          (reset),
      .enable         (enable),
      .ctl_in         (ctl_mid),
      .delta          (delta),
      .axis           (axis),
      .capsule_height (height_ff),
      .capsule_radius (radius_ff),
      .ctl_out        (ctl_out),
      .inside_res     (hit)
   );

   assign rsp_chan.valid      = ctl_out.valid;
   assign rsp_chan.inside_res = hit;
   assign rsp_chan.status     = ctl_out.status;

endmodule

// File: hdl/cpc_checker.sv
module cpc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_inside_res,
   input logic [1:0] rsp_status
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inside_res)
                                  && $stable(rsp_status))
      else $error("stalled transaction changed");

   a_status_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != cpc_pkg::STATUS_OK |-> !rsp_inside_res)
      else $error("inside with error status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= cpc_pkg::STATUS_BAD_AXIS)
      else $error("undefined status code");

endmodule

bind capsule_point_containment cpc_checker u_cpc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_inside_res (rsp_chan.inside_res),
   .rsp_status     (rsp_chan.status)
);
